@@ rtl/core/sxfs_pkg.sv @@
`default_nettype none

package sxfs_pkg;

  // Command codes of an input request.
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Fixed geometry of the word that holds one row, and of one sprite row.
  localparam int unsigned ROW_BITS     = 64;
  localparam int unsigned SPRITE_WIDTH = 8;
  // A row number as y_pos plus row_offset (at most 31 + 15).
  localparam int unsigned ROW_W        = 6;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and read its row
    logic commit;  // update the store and load the result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/sxfs_ctrl.sv @@
`default_nettype none

module sxfs_ctrl
  import sxfs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A loaded request always puts the controller in the execute state in the following cycle.
  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_EXEC)
    else $error("request load not followed by execute state");

  // A commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !cmd_o.load)
    else $error("second request loaded while one is in work");

endmodule

`default_nettype wire

@@ rtl/core/sxfs_datapath.sv @@
`default_nettype none

module sxfs_datapath
  import sxfs_pkg::*;
#(
  parameter int unsigned SCREEN_ROWS    = 32,
  parameter int unsigned SCREEN_COLUMNS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_cmd_t               cmd_i,
  input  wire logic [1:0]              command_i,
  input  wire logic [5:0]              x_pos_i,
  input  wire logic [4:0]              y_pos_i,
  input  wire logic [3:0]              row_offset_i,
  input  wire logic [SPRITE_WIDTH-1:0] sprite_byte_i,
  input  wire logic                    last_row_i,
  output logic                         collision_o,
  output logic [ROW_BITS-1:0]          row_bits_o
);

  localparam int unsigned AW = $clog2(SCREEN_ROWS);
  localparam logic [ROW_BITS-1:0] VIS_MASK = ~{ROW_BITS{1'b0}} << (ROW_BITS - SCREEN_COLUMNS);

  logic [ROW_BITS-1:0] mem_q [SCREEN_ROWS];
  logic [SCREEN_ROWS-1:0] row_vld_q;

  logic [ROW_W-1:0]        row_d, row_q;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic                    in_range_d, in_range_q;
  logic [1:0]              cmd_q;
  logic [5:0]              x_q;
  logic [SPRITE_WIDTH-1:0] sprite_q;
  logic                    last_q;
  logic [ROW_BITS-1:0]     rdata_q;
  logic                    rvld_q;
  logic                    acc_q;

  logic [ROW_BITS-1:0] line, old_row, new_row, row_res;
  logic                hit, coll_res, wr_en, clr_en, acc_upd;

  logic                collision_q;
  logic [ROW_BITS-1:0] row_bits_q;

  // Row selected by the request: target row for draw, y_pos for read and clear.
  always_comb begin
    if (command_i == CMD_DRAW) begin
      row_d = ROW_W'(y_pos_i) + ROW_W'(row_offset_i);
    end else begin
      row_d = ROW_W'(y_pos_i);
    end
  end

  assign in_range_d = {1'b0, row_d} < (ROW_W + 1)'(SCREEN_ROWS);
  assign rd_addr    = row_d[AW-1:0];
  assign wr_addr    = row_q[AW-1:0];

  // Capture the request and read its row from the store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q      <= row_d;
      in_range_q <= in_range_d;
      cmd_q      <= command_i;
      x_q        <= x_pos_i;
      sprite_q   <= sprite_byte_i;
      last_q     <= last_row_i;
      rdata_q    <= mem_q[rd_addr];
      rvld_q     <= row_vld_q[rd_addr];
    end
  end

  // Sprite placement, clipped at the right edge, and the XOR update.
  assign line    = ({sprite_q, {(ROW_BITS - SPRITE_WIDTH){1'b0}}} >> x_q) & VIS_MASK;
  assign old_row = rvld_q ? rdata_q : '0;
  assign new_row = old_row ^ line;
  assign hit     = in_range_q && ((old_row & line) != '0);

  // Result and store update per command.
  always_comb begin
    coll_res = 1'b0;
    row_res  = '0;
    wr_en    = 1'b0;
    clr_en   = 1'b0;
    acc_upd  = 1'b0;
    unique case (cmd_q)
      CMD_DRAW: begin
        coll_res = acc_q || hit;
        row_res  = in_range_q ? new_row : '0;
        wr_en    = in_range_q;
        acc_upd  = 1'b1;
      end
      CMD_CLEAR: begin
        clr_en = 1'b1;
      end
      CMD_READ: begin
        row_res = in_range_q ? old_row : '0;
      end
      default: ;
    endcase
  end

  // Row storage write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem_q[wr_addr] <= new_row;
    end
  end

  // Row valid bits make reset and clear take effect at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.commit && clr_en) begin
      row_vld_q <= '0;
    end else if (cmd_i.commit && wr_en) begin
      row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Collision accumulator restarts after the last row of a sprite.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else if (cmd_i.commit && acc_upd) begin
      acc_q <= last_q ? 1'b0 : coll_res;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      collision_q <= coll_res;
      row_bits_q  <= row_res;
    end
  end

  assign collision_o = collision_q;
  assign row_bits_o  = row_bits_q;

endmodule

`default_nettype wire

@@ rtl/core/sprite_xor_frame_store.sv @@
`default_nettype none

// One-bit frame store of SCREEN_ROWS rows by SCREEN_COLUMNS pixels, column c
// of a row at bit 63-c of row_bits_o. A draw request XORs one 8-pixel sprite
// row into row y_pos + row_offset and reports the collision flag collected
// over the sprite up to its last row; clear zeroes the screen and read
// returns one row. Each request is handled in two steps: the first captures it
// and reads its row from the single-port row memory, the second updates the row
// and loads the result register; a stalled result holds the second step until it
// drains. Reset and clear take effect at once through per-row valid bits, so
// there is no clearing pass.
module sprite_xor_frame_store
  import sxfs_pkg::*;
#(
  parameter int unsigned SCREEN_ROWS    = 32,
  parameter int unsigned SCREEN_COLUMNS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              command_i,
  input  wire logic [5:0]              x_pos_i,
  input  wire logic [4:0]              y_pos_i,
  input  wire logic [3:0]              row_offset_i,
  input  wire logic [SPRITE_WIDTH-1:0] sprite_byte_i,
  input  wire logic                    last_row_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         collision_o,
  output logic [ROW_BITS-1:0]          row_bits_o
);

  ctrl_cmd_t cmd;

  // Sequencing of requests and the result handshake.
  sxfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Row memory, sprite placement and collision logic.
  sxfs_datapath #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (command_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .row_offset_i  (row_offset_i),
    .sprite_byte_i (sprite_byte_i),
    .last_row_i    (last_row_i),
    .collision_o   (collision_o),
    .row_bits_o    (row_bits_o)
  );

endmodule

`default_nettype wire
